// ===== hw/rtl/kst_pkg.sv =====
// ----------------------------------------------------------------------------
// kst_pkg
// Shared types and constants of the maximum subarray sum tracker.
// ----------------------------------------------------------------------------
package kst_pkg;

  localparam int KST_MAX_LEN = 65536;
  localparam int VAL_W       = 32;
  localparam int SUM_W       = 47;
  localparam int IDX_W       = 17;
  localparam int TRIAL_W     = SUM_W + 2;

  localparam logic [SUM_W-1:0] SUM_LIMIT = {SUM_W{1'b1}};
  localparam logic [IDX_W-1:0] NO_START  = {IDX_W{1'b1}};

  typedef struct packed {
    logic             valid;
    logic [VAL_W-1:0] value;
    logic             last;
  } kst_item_t;

endpackage

// ===== hw/rtl/kst_in_stage.sv =====
// ----------------------------------------------------------------------------
// kst_in_stage
// Input register: captures one item and holds it until the tracker takes it.
// ----------------------------------------------------------------------------
module kst_in_stage (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [kst_pkg::VAL_W-1:0] in_value,
  input  logic                      in_last,
  input  logic                      take,
  output kst_pkg::kst_item_t        item
);
  import kst_pkg::*;

  logic             valid_r, valid_nxt;
  logic [VAL_W-1:0] value_r;
  logic             last_r;
  logic             accept;

  assign in_stall = valid_r && !take;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      value_r <= in_value;
      last_r  <= in_last;
    end
  end

  assign item.valid = valid_r;
  assign item.value = value_r;
  assign item.last  = last_r;

endmodule

// ===== hw/rtl/kst_tracker.sv =====
// ----------------------------------------------------------------------------
// kst_tracker
// Running sum and best run state, updated once per item, plus result register.
// ----------------------------------------------------------------------------
module kst_tracker #(
  parameter int MAX_LEN = kst_pkg::KST_MAX_LEN
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  kst_pkg::kst_item_t               item,
  output logic                             take,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic        [kst_pkg::SUM_W-1:0] out_best_sum,
  output logic signed [kst_pkg::IDX_W-1:0] out_best_start,
  output logic        [kst_pkg::IDX_W-1:0] out_best_count
);
  import kst_pkg::*;

  localparam int POS_W = (MAX_LEN > 2) ? $clog2(MAX_LEN) : 1;
  localparam int CNT_W = $clog2(MAX_LEN + 1);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LEN - 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_LEN);

  logic [SUM_W-1:0] run_sum_r,   run_sum_nxt;
  logic [POS_W-1:0] run_start_r, run_start_nxt;
  logic [CNT_W-1:0] run_count_r, run_count_nxt;
  logic [SUM_W-1:0] top_sum_r,   top_sum_nxt;
  logic [IDX_W-1:0] top_start_r, top_start_nxt;
  logic [CNT_W-1:0] top_count_r, top_count_nxt;
  logic [POS_W-1:0] position_r,  position_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic [TRIAL_W-1:0] trial;
  logic               positive;
  logic [SUM_W-1:0]   sum_new;
  logic [POS_W-1:0]   start_new;
  logic [CNT_W-1:0]   cnt_new;
  logic               better;
  logic               out_ready;
  logic               load_out;

  assign out_ready = !out_valid_r || !out_stall;
  assign take      = item.valid && (!item.last || out_ready);
  assign load_out  = take && item.last;

  assign trial     = {2'b00, run_sum_r}
                   + {{(TRIAL_W - VAL_W){item.value[VAL_W-1]}}, item.value};
  assign positive  = !trial[TRIAL_W-1] && (trial != '0);
  assign sum_new   = trial[SUM_W] ? SUM_LIMIT : trial[SUM_W-1:0];
  assign start_new = (run_sum_r == '0) ? position_r : run_start_r;
  assign cnt_new   = (run_count_r < CNT_MAX) ? run_count_r + 1'b1 : run_count_r;
  assign better    = (sum_new > top_sum_r)
                   || ((sum_new == top_sum_r) && (cnt_new < top_count_r));

  always_comb begin
    run_sum_nxt   = run_sum_r;
    run_start_nxt = run_start_r;
    run_count_nxt = run_count_r;
    top_sum_nxt   = top_sum_r;
    top_start_nxt = top_start_r;
    top_count_nxt = top_count_r;
    position_nxt  = position_r;
    if (take) begin
      if (positive) begin
        run_sum_nxt   = sum_new;
        run_start_nxt = start_new;
        run_count_nxt = cnt_new;
        if (better) begin
          top_sum_nxt   = sum_new;
          top_start_nxt = IDX_W'(start_new);
          top_count_nxt = cnt_new;
        end
      end else begin
        run_sum_nxt   = '0;
        run_count_nxt = '0;
      end
      if (position_r < POS_MAX) begin
        position_nxt = position_r + 1'b1;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || load_out) begin
      run_sum_r   <= '0;
      run_start_r <= '0;
      run_count_r <= '0;
      top_sum_r   <= '0;
      top_start_r <= NO_START;
      top_count_r <= '0;
      position_r  <= '0;
    end else begin
      run_sum_r   <= run_sum_nxt;
      run_start_r <= run_start_nxt;
      run_count_r <= run_count_nxt;
      top_sum_r   <= top_sum_nxt;
      top_start_r <= top_start_nxt;
      top_count_r <= top_count_nxt;
      position_r  <= position_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_best_sum   <= top_sum_nxt;
      out_best_start <= $signed(top_start_nxt);
      out_best_count <= IDX_W'(top_count_nxt);
    end
  end

  assign out_valid = out_valid_r;

  // empty run and positive run sum go together
  a_run_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (run_sum_r == '0) == (run_count_r == '0))
    else $error("run sum and run count disagree");

  a_top_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (top_sum_r == '0) == (top_count_r == '0))
    else $error("best sum and best count disagree");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> (position_r == '0) && (top_sum_r == '0) && out_valid_r)
    else $error("state not cleared after last item");

endmodule

// ===== hw/rtl/max_subarray_sum_tracker_core.sv =====
// ----------------------------------------------------------------------------
// max_subarray_sum_tracker_core
// Streaming maximum positive run sum tracker with best start and length.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall carry one signed value per item, with
// in_last on the final item of a sequence. Output channel: out_valid/out_stall
// carry one result per sequence: best sum (0 if no positive run), zero-based
// start (-1 if none) and length. Ties on sum go to the shorter run.
// A last item goes from the input register through the update logic into the
// result register. Throughput: one item per cycle unless a last item waits on
// a stalled result; the whole update is one add, one saturate
// and one compare between the input register and the state registers.
// A stalled result holds; while it waits, non-last items keep flowing and only
// a following last item holds in the input register, asserting in_stall.
// Reset (rst_n low, synchronous) clears both channels and returns the state
// to an empty sequence. Positions saturate at MAX_LEN-1, lengths at MAX_LEN.
// ----------------------------------------------------------------------------
module max_subarray_sum_tracker_core #(
  parameter int MAX_LEN = kst_pkg::KST_MAX_LEN
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [kst_pkg::VAL_W-1:0] in_value,
  input  logic                             in_last,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic        [kst_pkg::SUM_W-1:0] out_best_sum,
  output logic signed [kst_pkg::IDX_W-1:0] out_best_start,
  output logic        [kst_pkg::IDX_W-1:0] out_best_count
);
  import kst_pkg::*;

  kst_item_t item;
  logic      take;

  kst_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_value (in_value),
    .in_last  (in_last),
    .take     (take),
    .item     (item)
  );

  kst_tracker #(
    .MAX_LEN (MAX_LEN)
  ) u_trk (
    .clk            (clk),
    .rst_n          (rst_n),
    .item           (item),
    .take           (take),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_best_sum   (out_best_sum),
    .out_best_start (out_best_start),
    .out_best_count (out_best_count)
  );

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the streaming maximum positive run sum tracker.
// ----------------------------------------------------------------------------
// A directed table covers the value extremes, sequences with no positive run,
// the tie that goes to the shorter run and a run that restarts on a zero sum.
// Random sequences follow. Untyped results check against a local tracker
// model. Both channels idle in random short bursts, except near the end.
// ----------------------------------------------------------------------------
module testbench;
  import kst_pkg::*;

  localparam int RANDOM_ITEMS = 2000;
  localparam int CALM_ITEMS   = 200;
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int PLAN_ROWS    = 22;
  localparam int BEST_DEPTH   = 16;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [IDX_W-1:0] start;
    logic [IDX_W-1:0] count;
  } best_run_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    int               reps;
    logic             last;
    logic             typed;
    best_run_t        want;
  } plan_row_t;

  localparam best_run_t NO_RUN = '{'0, NO_START, '0};

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic [VAL_W-1:0]     in_value  = '0;
  logic                 in_last   = 1'b0;
  logic                 out_stall = 1'b0;
  logic                 in_stall;
  logic                 out_valid;
  logic [SUM_W-1:0]     out_best_sum;
  logic [IDX_W-1:0]     out_best_start;
  logic [IDX_W-1:0]     out_best_count;

  // tracker model state
  logic [SUM_W-1:0]     run_total;
  logic [15:0]          run_first;
  logic [IDX_W-1:0]     run_len;
  logic [SUM_W-1:0]     top_total;
  logic [IDX_W-1:0]     top_first;
  logic [IDX_W-1:0]     top_len;
  logic [15:0]          pos;

  best_run_t            best_fifo [BEST_DEPTH];
  logic [3:0]           best_wr    = '0;
  logic [3:0]           best_rd    = '0;
  best_run_t            pending;
  bit                   calm       = 1'b0;
  int                   mismatches = 0;
  int                   stall_left = 0;
  int                   cycle_count = 0;

  max_subarray_sum_tracker_core u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_value       (in_value),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_best_sum   (out_best_sum),
    .out_best_start (out_best_start),
    .out_best_count (out_best_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void clear_tracker();
    run_total = '0;
    run_first = '0;
    run_len   = '0;
    top_total = '0;
    top_first = NO_START;
    top_len   = '0;
    pos       = '0;
  endfunction

  // Returns 1 when the item closes a sequence; res then holds the best run.
  function automatic logic track_item(input logic [VAL_W-1:0] v, input logic is_last,
                                      output best_run_t res);
    logic [TRIAL_W-1:0] trial;
    trial = {2'b00, run_total} + {{(TRIAL_W-VAL_W){v[VAL_W-1]}}, v};
    if (!trial[TRIAL_W-1] && trial != '0) begin
      if (run_total == '0) run_first = pos;
      run_total = trial[TRIAL_W-2] ? SUM_LIMIT : trial[SUM_W-1:0];
      if (run_len < IDX_W'(KST_MAX_LEN)) run_len++;
      if (run_total > top_total || (run_total == top_total && run_len < top_len)) begin
        top_total = run_total;
        top_first = {1'b0, run_first};
        top_len   = run_len;
      end
    end else begin
      run_total = '0;
      run_len   = '0;
    end
    if (pos < 16'(KST_MAX_LEN - 1)) pos++;
    res = '{top_total, top_first, top_len};
    if (is_last) clear_tracker();
    return is_last;
  endfunction

  task automatic report_mismatch(input string field, input longint got, input longint want);
    $display("mismatch on %s: got %0d, expected %0d", field, got, want);
    mismatches++;
  endtask

  task automatic feed_item(input logic [VAL_W-1:0] v, input logic is_last,
                           input logic typed, input best_run_t want);
    best_run_t res;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    in_last  <= is_last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (track_item(v, is_last, res)) begin
      best_fifo[best_wr] = typed ? want : res;
      best_wr = best_wr + 4'd1;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 2);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (best_wr == best_rd) begin
        report_mismatch("result with none pending", out_best_sum, 0);
      end else begin
        pending = best_fifo[best_rd];
        best_rd = best_rd + 4'd1;
        if (out_best_sum !== pending.sum)
          report_mismatch("best_sum", out_best_sum, pending.sum);
        if (out_best_start !== pending.start)
          report_mismatch("best_start", $signed(out_best_start), $signed(pending.start));
        if (out_best_count !== pending.count)
          report_mismatch("best_count", out_best_count, pending.count);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    plan_row_t        plan [PLAN_ROWS];
    logic [VAL_W-1:0] v;
    int               sent;
    int               seq_len;

    plan = '{
      '{-32'sd5,          1,        1'b1, 1'b1, NO_RUN},
      '{32'd0,            1,        1'b1, 1'b1, NO_RUN},
      '{32'h7FFF_FFFF,    1,        1'b1, 1'b1, '{47'd2147483647, 17'd0, 17'd1}},
      '{32'h8000_0000,    1,        1'b1, 1'b1, NO_RUN},
      '{32'd1,            1,        1'b1, 1'b1, '{47'd1, 17'd0, 17'd1}},
      '{32'd3,            1,        1'b0, 1'b0, NO_RUN},
      '{32'hFFFF_FFFF,    1,        1'b0, 1'b0, NO_RUN},
      '{32'd2,            1,        1'b1, 1'b0, NO_RUN},
      // tie on sum goes to the shorter run
      '{32'd2,            1,        1'b0, 1'b0, NO_RUN},
      '{32'd3,            1,        1'b0, 1'b0, NO_RUN},
      '{-32'sd100,        1,        1'b0, 1'b0, NO_RUN},
      '{32'd5,            1,        1'b1, 1'b0, NO_RUN},
      // zero sum drops the run
      '{32'd5,            1,        1'b0, 1'b0, NO_RUN},
      '{-32'sd5,          1,        1'b0, 1'b0, NO_RUN},
      '{32'd5,            1,        1'b1, 1'b0, NO_RUN},
      '{32'h8000_0000,    1,        1'b0, 1'b0, NO_RUN},
      '{32'h7FFF_FFFF,    1,        1'b0, 1'b0, NO_RUN},
      '{32'hFFFF_FFFF,    1,        1'b0, 1'b0, NO_RUN},
      '{32'h7FFF_FFFF,    1,        1'b1, 1'b0, NO_RUN},
      '{32'hFFFF_FFFF,    2,        1'b0, 1'b0, NO_RUN},
      '{-32'sd7,          1,        1'b1, 1'b1, NO_RUN},
      '{32'd1,            3,        1'b1, 1'b0, NO_RUN}
    };

    clear_tracker();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (int row = 0; row < PLAN_ROWS; row++) begin
      for (int rep = 0; rep < plan[row].reps; rep++) begin
        feed_item(plan[row].value, plan[row].last && rep == plan[row].reps - 1,
                  plan[row].typed, plan[row].want);
      end
    end

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      seq_len = ($urandom_range(0, 15) == 0) ? 1 : $urandom_range(2, 30);
      for (int k = 0; k < seq_len; k++) begin
        calm = (sent >= RANDOM_ITEMS - CALM_ITEMS);
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: v = VAL_W'($urandom_range(0, 200)) - VAL_W'(100);
          6:                v = $urandom;
          7:                v = 32'h7FFF_FFFF;
          8:                v = 32'h8000_0000;
          default:          v = VAL_W'($urandom_range(0, 2000000)) - VAL_W'(1000000);
        endcase
        feed_item(v, k == seq_len - 1, 1'b0, NO_RUN);
        sent++;
      end
    end

    in_valid <= 1'b0;
    in_last  <= 1'b0;
    while (best_wr != best_rd) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
